FILE: rtl/isotp_pkg.sv
// Package: shared types, status codes and buffer constants for the ISO-TP receive reassembler.
package isotp_pkg;

	// reassembly buffer size and derived address width
	localparam int BUFFER_BYTES = 4096;
	localparam int BUF_AW = $clog2(BUFFER_BYTES);
	localparam int POS_W = 14;

	// status codes of a result
	localparam logic [2:0] STATUS_READ = 3'd0;
	localparam logic [2:0] STATUS_IGNORED = 3'd1;
	localparam logic [2:0] STATUS_SINGLE = 3'd2;
	localparam logic [2:0] STATUS_FIRST = 3'd3;
	localparam logic [2:0] STATUS_CONS_STORED = 3'd4;
	localparam logic [2:0] STATUS_CONS_DONE = 3'd5;
	localparam logic [2:0] STATUS_REJECTED = 3'd6;

	// frame types from the top nibble of the control byte
	localparam logic [3:0] FT_SINGLE = 4'h0;
	localparam logic [3:0] FT_FIRST = 4'h1;
	localparam logic [3:0] FT_CONSEC = 4'h2;

	// action codes
	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// register indexes on the configuration port
	localparam logic [1:0] REG_FC_ID = 2'd0;
	localparam logic [1:0] REG_BLOCK_SIZE = 2'd1;
	localparam logic [1:0] REG_SEP_TIME = 2'd2;

	localparam logic [3:0] MAX_FRAME_LEN = 4'd8;
	localparam logic [2:0] MAX_SINGLE_LEN = 3'd7;

	// one input item
	typedef struct packed {
		logic        action;
		logic [3:0]  frame_len;
		logic [7:0]  frame_byte0;
		logic [7:0]  frame_byte1;
		logic [7:0]  frame_byte2;
		logic [7:0]  frame_byte3;
		logic [7:0]  frame_byte4;
		logic [7:0]  frame_byte5;
		logic [7:0]  frame_byte6;
		logic [7:0]  frame_byte7;
		logic [11:0] read_index;
	} item_t;

	// one result item
	typedef struct packed {
		logic [2:0]  status;
		logic        message_done;
		logic [11:0] message_length;
		logic        send_flow_control;
		logic [7:0]  read_data;
	} result_t;

endpackage

FILE: rtl/isotp_ram.sv
// Module: single-port synchronous RAM with registered read data.
module isotp_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one access per cycle: write or read at the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/isotp_receive_reassembler.sv
// Module: top level of the ISO-TP receive reassembler (frame decode, byte writer, APB registers).
//
// Channel   Signals                              Transfer
// item      start, busy, item                    start high while busy low
// result    result_strobe, result                one cycle per strobe, no backpressure
// config    psel, penable, pwrite, paddr, ...    APB access phase, pready always high
//
// A frame is decoded on accept, then its 0 to 7 payload bytes are written in order through the
// single buffer port; the result strobes in the cycle after the last write.
// A read presents its address on accept, then the registered RAM data is captured.
// busy is high while bytes are written or a read is in flight.
// Reset clears reception state, config registers and sequencer; buffer contents stay undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.
module isotp_receive_reassembler (
	input  logic                    clk,
	input  logic                    arst_n,
	// item channel
	input  logic                    start,
	output logic                    busy,
	input  isotp_pkg::item_t        item,
	// result channel
	output logic                    result_strobe,
	output isotp_pkg::result_t      result,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [3:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_RDWAIT} state_t;

	localparam int AW = isotp_pkg::BUF_AW;
	localparam int PW = isotp_pkg::POS_W;

	// configuration registers
	logic [10:0] fc_id_q;
	logic [7:0]  block_size_q;
	logic [7:0]  sep_time_q;

	// reception state
	logic [11:0] decl_len_q;
	logic [12:0] bytes_rcvd_q;
	logic [3:0]  exp_seq_q;
	logic        receiving_q;

	// sequencer and byte writer
	state_t             state_q;
	logic [2:0]         cnt_q;
	logic [PW-1:0]      pos_q;
	logic [7:0]         sh_q [7];
	logic               rd_ok_q;
	logic               strobe_q;
	isotp_pkg::result_t result_q;

	// decode of the incoming item
	logic        accept;
	logic [3:0]  flen;
	logic [3:0]  ftype;
	logic [3:0]  low;
	logic [7:0]  fb [8];
	logic [7:0]  src [7];
	logic [2:0]  n_d;
	logic [12:0] base_d;
	logic        from_b2_d;
	logic [2:0]  status_d;
	logic        done_d;
	logic        fc_d;
	logic [11:0] decl_len_d;
	logic [12:0] bytes_rcvd_d;
	logic [3:0]  exp_seq_d;
	logic        receiving_d;
	logic [3:0]  flen_m1;
	logic [3:0]  flen_m2;

	// buffer port
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_rdata;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign result = result_q;
	assign pready = 1'b1;

	assign fb[0] = item.frame_byte0;
	assign fb[1] = item.frame_byte1;
	assign fb[2] = item.frame_byte2;
	assign fb[3] = item.frame_byte3;
	assign fb[4] = item.frame_byte4;
	assign fb[5] = item.frame_byte5;
	assign fb[6] = item.frame_byte6;
	assign fb[7] = item.frame_byte7;

	assign flen = (item.frame_len > isotp_pkg::MAX_FRAME_LEN) ?
		isotp_pkg::MAX_FRAME_LEN : item.frame_len;
	assign ftype = fb[0][7:4];
	assign low = fb[0][3:0];
	assign flen_m1 = flen - 4'd1;
	assign flen_m2 = flen - 4'd2;

	// payload bytes in write order: first frames skip the length byte
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			src[i] = from_b2_d ? fb[i + 2] : fb[i + 1];
		end
		src[6] = from_b2_d ? 8'd0 : fb[7];
	end

	// frame decode and next reception state
	always_comb begin
		n_d = 3'd0;
		base_d = 13'd0;
		from_b2_d = 1'b0;
		status_d = isotp_pkg::STATUS_IGNORED;
		done_d = 1'b0;
		fc_d = 1'b0;
		decl_len_d = decl_len_q;
		bytes_rcvd_d = bytes_rcvd_q;
		exp_seq_d = exp_seq_q;
		receiving_d = receiving_q;
		priority if (item.action == isotp_pkg::ACT_READ) begin
			status_d = isotp_pkg::STATUS_READ;
		end else if (flen == 4'd0) begin
			status_d = isotp_pkg::STATUS_IGNORED;
		end else if (ftype == isotp_pkg::FT_SINGLE) begin
			n_d = (low > 4'(isotp_pkg::MAX_SINGLE_LEN)) ? isotp_pkg::MAX_SINGLE_LEN : low[2:0];
			decl_len_d = 12'(n_d);
			status_d = isotp_pkg::STATUS_SINGLE;
			done_d = 1'b1;
		end else if (ftype == isotp_pkg::FT_FIRST) begin
			if (flen >= 4'd2) begin
				n_d = flen_m2[2:0];
				from_b2_d = 1'b1;
				decl_len_d = {low, item.frame_byte1};
				bytes_rcvd_d = 13'(n_d);
				exp_seq_d = 4'd1;
				receiving_d = 1'b1;
				status_d = isotp_pkg::STATUS_FIRST;
				fc_d = 1'b1;
			end
		end else if (ftype == isotp_pkg::FT_CONSEC) begin
			if (!receiving_q || low != exp_seq_q) begin
				status_d = isotp_pkg::STATUS_REJECTED;
			end else begin
				n_d = flen_m1[2:0];
				base_d = bytes_rcvd_q;
				bytes_rcvd_d = bytes_rcvd_q + 13'(n_d);
				exp_seq_d = exp_seq_q + 4'd1;
				if (bytes_rcvd_d >= {1'b0, decl_len_q}) begin
					receiving_d = 1'b0;
					status_d = isotp_pkg::STATUS_CONS_DONE;
					done_d = 1'b1;
				end else begin
					status_d = isotp_pkg::STATUS_CONS_STORED;
				end
			end
		end
	end

	// reception state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_len_q <= '0;
			bytes_rcvd_q <= '0;
			exp_seq_q <= '0;
			receiving_q <= 1'b0;
		end else if (accept) begin
			decl_len_q <= decl_len_d;
			bytes_rcvd_q <= bytes_rcvd_d;
			exp_seq_q <= exp_seq_d;
			receiving_q <= receiving_d;
		end
	end

	// buffer port: writes walk pos_q, reads take the index on accept
	assign mem_we = (state_q == ST_WRITE) && (pos_q < PW'(isotp_pkg::BUFFER_BYTES));
	assign mem_addr = (state_q == ST_WRITE) ? pos_q[AW-1:0] : item.read_index[AW-1:0];

	isotp_ram #(
		.DEPTH(isotp_pkg::BUFFER_BYTES),
		.WIDTH(8),
		.AW(AW)
	) u_buf (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(sh_q[0]),
		.rdata(mem_rdata)
	);

	// payload registers of the byte writer
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 7; i++) begin
				sh_q[i] <= src[i];
			end
			pos_q <= PW'(base_d);
			rd_ok_q <= ({2'b00, item.read_index} < PW'(isotp_pkg::BUFFER_BYTES));
		end else if (state_q == ST_WRITE) begin
			for (int i = 0; i < 6; i++) begin
				sh_q[i] <= sh_q[i + 1];
			end
			sh_q[6] <= 8'd0;
			pos_q <= pos_q + PW'(1);
		end
	end

	// sequencer with registered result and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						result_q.status <= status_d;
						result_q.message_done <= done_d;
						result_q.message_length <= decl_len_d;
						result_q.send_flow_control <= fc_d;
						result_q.read_data <= 8'd0;
						cnt_q <= n_d;
						if (item.action == isotp_pkg::ACT_READ) begin
							state_q <= ST_RDWAIT;
						end else if (n_d != 3'd0) begin
							state_q <= ST_WRITE;
						end else begin
							strobe_q <= 1'b1;
						end
					end
				end
				ST_WRITE: begin
					cnt_q <= cnt_q - 3'd1;
					if (cnt_q == 3'd1) begin
						strobe_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RDWAIT: begin
					result_q.read_data <= rd_ok_q ? mem_rdata : 8'd0;
					strobe_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// configuration registers, written in the APB access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_id_q <= '0;
			block_size_q <= '0;
			sep_time_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				isotp_pkg::REG_FC_ID: fc_id_q <= pwdata[10:0];
				isotp_pkg::REG_BLOCK_SIZE: block_size_q <= pwdata[7:0];
				isotp_pkg::REG_SEP_TIME: sep_time_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			isotp_pkg::REG_FC_ID: prdata = {21'd0, fc_id_q};
			isotp_pkg::REG_BLOCK_SIZE: prdata = {24'd0, block_size_q};
			isotp_pkg::REG_SEP_TIME: prdata = {24'd0, sep_time_q};
			default: prdata = 32'd0;
		endcase
	end

endmodule
